// File: hw/rtl/color_run_blob_finder_top_macros.svh
// Assertion macros for the color run blob finder RTL.
// Included by crbf_run_track, the module that carries concurrent checks.
`ifndef COLOR_RUN_BLOB_FINDER_TOP_MACROS_SVH
`define COLOR_RUN_BLOB_FINDER_TOP_MACROS_SVH

// Same-cycle implication under synchronous reset.
`define CRBF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication under synchronous reset.
`define CRBF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/crbf_pkg.sv
// Shared types and constants for the color run blob finder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package crbf_pkg;

  localparam int MaxWidth = 1024;
  localparam logic [10:0] LenMax = 11'h7FF;
  localparam logic [9:0] CenterMax = 10'h3FF;

  localparam logic [7:0] RstTargetRed = 8'd255;
  localparam logic [7:0] RstTargetGreen = 8'd138;
  localparam logic [7:0] RstTargetBlue = 8'd20;
  localparam logic [8:0] RstTolerance = 9'd80;
  localparam logic [10:0] RstFrameWidth = 11'd160;
  localparam logic [10:0] RstFrameHeight = 11'd120;
  localparam logic [9:0] RstRowsScanned = 10'd20;

  typedef enum logic [2:0] {
    RegTargetRed    = 3'd0,
    RegTargetGreen  = 3'd1,
    RegTargetBlue   = 3'd2,
    RegTolerance    = 3'd3,
    RegFrameWidth   = 3'd4,
    RegFrameHeight  = 3'd5,
    RegRowsScanned  = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [7:0]  target_red;
    logic [7:0]  target_green;
    logic [7:0]  target_blue;
    logic [8:0]  color_tolerance;
    logic [10:0] frame_width;
    logic [10:0] frame_height;
    logic [9:0]  rows_scanned;
  } cfg_t;

  typedef struct packed {
    logic       scanned;
    logic       hit;
    logic       row_end;
    logic [9:0] column;
    logic       frame_end;
  } pix_t;

  typedef struct packed {
    logic        found;
    logic [9:0]  ball_x;
    logic [10:0] ball_size;
  } result_t;

endpackage

// File: hw/rtl/crbf_in_stage.sv
// Input register for pixel beats plus color and row classification.
// Depends on crbf_pkg.
`timescale 1ns / 1ps

module crbf_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  crbf_pkg::cfg_t cfg,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     red,
  input  logic [7:0]     green,
  input  logic [7:0]     blue,
  input  logic [9:0]     column,
  input  logic [9:0]     line,
  input  logic           frame_end,
  input  logic           take,
  output logic           pix_valid,
  output crbf_pkg::pix_t pix
);
  import crbf_pkg::*;

  logic        valid;
  logic [7:0]  red_q, green_q, blue_q;
  logic [9:0]  column_q, line_q;
  logic        frame_end_q;

  logic [10:0] width_eff;
  logic [10:0] row_gap;
  logic        in_row;
  logic        col_ok;
  logic        row_ok;
  logic        hit;

  function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  assign in_ready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      red_q       <= red;
      green_q     <= green;
      blue_q      <= blue;
      column_q    <= column;
      line_q      <= line;
      frame_end_q <= frame_end;
    end
  end

  always_comb begin
    width_eff = (cfg.frame_width > 11'(MaxWidth)) ? 11'(MaxWidth) : cfg.frame_width;
    col_ok    = ({1'b0, column_q} < width_eff);
    in_row    = ({1'b0, line_q} < cfg.frame_height);
    row_gap   = cfg.frame_height - 11'd1 - {1'b0, line_q};
    row_ok    = in_row && !row_gap[0] && (row_gap[10:1] < cfg.rows_scanned);
    hit = ({1'b0, abs_diff(red_q, cfg.target_red)} < cfg.color_tolerance) &&
          ({1'b0, abs_diff(green_q, cfg.target_green)} < cfg.color_tolerance) &&
          ({1'b0, abs_diff(blue_q, cfg.target_blue)} < cfg.color_tolerance);
    pix.scanned   = col_ok && row_ok;
    pix.hit       = hit;
    pix.row_end   = ({1'b0, column_q} == (width_eff - 11'd1));
    pix.column    = column_q;
    pix.frame_end = frame_end_q;
  end

  assign pix_valid = valid;

endmodule

// File: hw/rtl/crbf_run_track.sv
// Run tracker: open run, best run of the frame, frame-end report.
// Depends on crbf_pkg and the assertion macro header.
`timescale 1ns / 1ps

`include "color_run_blob_finder_top_macros.svh"

module crbf_run_track (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  crbf_pkg::pix_t    pix,
  output logic              res_valid,
  output crbf_pkg::result_t res
);
  import crbf_pkg::*;

  logic [9:0]  run_begin, run_begin_next;
  logic [10:0] run_length, run_length_next;
  logic [10:0] best_length, best_length_next;
  logic [9:0]  best_center, best_center_next;

  logic [9:0]  beg0, beg1, close_beg;
  logic [10:0] len0, len1, close_len;
  logic        do_close;
  logic [10:0] center_sum;

  always_comb begin
    len0 = (pix.column == 10'd0) ? 11'd0 : run_length;
    beg0 = (pix.column == 10'd0) ? 10'd0 : run_begin;
    beg1 = (len0 == 11'd0) ? pix.column : beg0;
    len1 = (len0 == LenMax) ? len0 : (len0 + 11'd1);

    run_begin_next   = run_begin;
    run_length_next  = run_length;
    best_length_next = best_length;
    best_center_next = best_center;
    do_close  = 1'b0;
    close_len = len0;
    close_beg = beg0;

    if (pix.scanned) begin
      if (pix.hit) begin
        run_begin_next  = beg1;
        run_length_next = len1;
        close_len = len1;
        close_beg = beg1;
        do_close  = pix.row_end;
      end else begin
        do_close = 1'b1;
      end
    end

    center_sum = {1'b0, close_beg} + {1'b0, close_len[10:1]};
    if (do_close) begin
      if (close_len != 11'd0 && close_len > best_length) begin
        best_length_next = close_len;
        best_center_next = center_sum[10] ? CenterMax : center_sum[9:0];
      end
      run_begin_next  = 10'd0;
      run_length_next = 11'd0;
    end

    res.found     = (best_length_next != 11'd0);
    res.ball_x    = res.found ? best_center_next : 10'd0;
    res.ball_size = res.found ? best_length_next : 11'd0;
    res_valid     = advance && pix.frame_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_begin   <= 10'd0;
      run_length  <= 11'd0;
      best_length <= 11'd0;
      best_center <= 10'd0;
    end else if (advance) begin
      if (pix.frame_end) begin
        run_begin   <= 10'd0;
        run_length  <= 11'd0;
        best_length <= 11'd0;
        best_center <= 10'd0;
      end else begin
        run_begin   <= run_begin_next;
        run_length  <= run_length_next;
        best_length <= best_length_next;
        best_center <= best_center_next;
      end
    end
  end

  `CRBF_ASSERT_NEXT(a_clear_after_frame, clk, rst, advance && pix.frame_end, best_length == 11'd0 && run_length == 11'd0, "state not cleared after frame end")
  `CRBF_ASSERT_NEXT(a_best_grows, clk, rst, advance && !pix.frame_end, best_length >= $past(best_length), "best run shrank inside a frame")
  `CRBF_ASSERT_NOW(a_found_size, clk, rst, res_valid, res.found == (res.ball_size != 11'd0), "found flag disagrees with run size")

endmodule

// File: hw/rtl/crbf_out_stage.sv
// Output register for result beats.
// Depends on crbf_pkg.
`timescale 1ns / 1ps

module crbf_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              res_valid,
  input  crbf_pkg::result_t res,
  output logic              busy,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              found,
  output logic [9:0]        ball_x,
  output logic [10:0]       ball_size
);
  import crbf_pkg::*;

  logic    valid;
  logic    valid_next;
  result_t data;

  assign valid_next = res_valid || (valid && !out_ready);
  assign busy       = valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
    if (res_valid) begin
      data <= res;
    end
  end

  assign out_valid = valid;
  assign found     = data.found;
  assign ball_x    = data.ball_x;
  assign ball_size = data.ball_size;

endmodule

// File: hw/rtl/color_run_blob_finder_top.sv
// Color run blob finder: one pixel beat per clock in unless stalled, one result beat
// per frame out. Every pixel beat is registered, classified and folded into the run
// tracker in the next cycle unless stalled, so a beat can be accepted every clock;
// a frame's result passes the input register, then the output register. The only
// stall is a frame_end beat meeting a result beat not yet taken. No clearing pass
// after reset. Depends on crbf_pkg, crbf_in_stage, crbf_run_track, crbf_out_stage.
`timescale 1ns / 1ps

module color_run_blob_finder_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [10:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic [9:0]  column,
  input  logic [9:0]  line,
  input  logic        frame_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        found,
  output logic [9:0]  ball_x,
  output logic [10:0] ball_size
);
  import crbf_pkg::*;

  cfg_t    cfg;
  pix_t    pix;
  result_t res;
  logic    pix_valid;
  logic    take;
  logic    res_valid;
  logic    out_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_red      <= RstTargetRed;
      cfg.target_green    <= RstTargetGreen;
      cfg.target_blue     <= RstTargetBlue;
      cfg.color_tolerance <= RstTolerance;
      cfg.frame_width     <= RstFrameWidth;
      cfg.frame_height    <= RstFrameHeight;
      cfg.rows_scanned    <= RstRowsScanned;
    end else if (cfg_we) begin
      case (cfg_index)
        RegTargetRed:   cfg.target_red      <= cfg_data[7:0];
        RegTargetGreen: cfg.target_green    <= cfg_data[7:0];
        RegTargetBlue:  cfg.target_blue     <= cfg_data[7:0];
        RegTolerance:   cfg.color_tolerance <= cfg_data[8:0];
        RegFrameWidth:  cfg.frame_width     <= cfg_data;
        RegFrameHeight: cfg.frame_height    <= cfg_data;
        RegRowsScanned: cfg.rows_scanned    <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  assign take = pix_valid && (!pix.frame_end || !out_busy);

  crbf_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .column    (column),
    .line      (line),
    .frame_end (frame_end),
    .take      (take),
    .pix_valid (pix_valid),
    .pix       (pix)
  );

  crbf_run_track u_track (
    .clk       (clk),
    .rst       (rst),
    .advance   (take),
    .pix       (pix),
    .res_valid (res_valid),
    .res       (res)
  );

  crbf_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .busy      (out_busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .found     (found),
    .ball_x    (ball_x),
    .ball_size (ball_size)
  );

endmodule
